/* src/clw_pkg.sv */
package clw_pkg;

    // Item kinds carried in tuser
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_MSG  = 2'd1;
    localparam logic [1:0] OP_LINK = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FLOOR   = 2'd0;
    localparam logic [1:0] CFG_CEILING = 2'd1;
    localparam logic [1:0] CFG_DEFAULT = 2'd2;
    localparam logic [1:0] CFG_STALE   = 2'd3;

    // Field limits
    localparam int unsigned MANEUVER_MAX = 15;
    localparam int unsigned UNIT_MAX     = 3;
    localparam int unsigned BATT_MAX     = 100;

    // Grace time is period * 1000 * 5 / 2 ms
    localparam int unsigned GRACE_MS_PER_S = 1000 * 5 / 2;

    // Reset values
    localparam logic [15:0] FLOOR_RST    = 16'd15;
    localparam logic [15:0] CEILING_RST  = 16'd3600;
    localparam logic [15:0] DEFAULT_RST  = 16'd900;
    localparam logic [19:0] STALE_RST    = 20'd120000;
    localparam logic [27:0] GRACE_RST    = 28'd2250000;
    localparam logic [7:0]  BATT_UNKNOWN = 8'hFF;

    // Payload widths
    localparam int unsigned S_TDATA_W = 168;
    localparam int unsigned M_TDATA_W = 48;

    typedef struct packed {
        logic [15:0] period_floor_s;
        logic [15:0] period_ceiling_s;
        logic [15:0] default_period_s;
        logic [19:0] route_life_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  opcode;
        logic        link_up;
        logic        beat_present;
        logic [31:0] beat_period_s;
        logic        route_present;
        logic [31:0] route_code;
        logic        dist_present;
        logic [31:0] dist_value;
        logic        unit_present;
        logic [31:0] unit_code;
        logic        batt_present;
        logic [31:0] batt_value;
    } t_item;

    typedef struct packed {
        logic        link_state;
        logic        companion_ok;
        logic        beat_armed;
        logic [27:0] beat_left_ms;
        logic [27:0] grace_ms;
        logic [3:0]  route_held;
        logic        route_armed;
        logic [19:0] route_left_ms;
        logic [30:0] dist_held;
        logic [1:0]  unit_held;
        logic [7:0]  batt_held;
    } t_state;

    typedef struct packed {
        logic        alive;
        logic        route_active;
        logic [3:0]  route_out;
        logic [30:0] dist_out;
        logic [1:0]  unit_out;
        logic [7:0]  batt_out;
        logic        changed;
    } t_result;

endpackage

/* src/clw_step.sv */
module clw_step #(
    parameter int unsigned MANEUVER_MAX = clw_pkg::MANEUVER_MAX,
    parameter int unsigned UNIT_MAX     = clw_pkg::UNIT_MAX
) (
    input  clw_pkg::t_cfg    i_cfg,
    input  clw_pkg::t_state  i_state,
    input  clw_pkg::t_item   i_item,
    output clw_pkg::t_state  o_state,
    output clw_pkg::t_result o_result
);

    logic [31:0]      per_src;
    logic             below_floor;
    logic             above_ceil;
    logic [15:0]      per_clamped;
    logic [27:0]      grace_new;
    logic             route_ok;
    logic             unit_ok;
    logic             batt_ok;
    logic [3:0]       route_new;
    logic [30:0]      dist_new;
    logic [1:0]       unit_new;
    logic [7:0]       batt_new;
    clw_pkg::t_state  n_st;
    logic             dirty;

    // Pick the period to clamp: declared one for a message, default for a link change
    assign per_src = (i_item.opcode == clw_pkg::OP_LINK)
                   ? {16'd0, i_cfg.default_period_s} : i_item.beat_period_s;

    // Clamp to floor, then ceiling (ceiling wins)
    assign below_floor = per_src[31] || (per_src < {16'd0, i_cfg.period_floor_s});
    assign above_ceil  = below_floor
                       ? (i_cfg.period_floor_s > i_cfg.period_ceiling_s)
                       : ((per_src[31:16] != 16'd0) || (per_src[15:0] > i_cfg.period_ceiling_s));
    assign per_clamped = above_ceil  ? i_cfg.period_ceiling_s :
                         below_floor ? i_cfg.period_floor_s : per_src[15:0];
    assign grace_new   = 28'(28'(per_clamped) * 28'(clw_pkg::GRACE_MS_PER_S));

    // Validate message fields
    assign route_ok = !i_item.route_code[31] && (i_item.route_code != 32'd0)
                   && (i_item.route_code <= 32'(MANEUVER_MAX));
    assign unit_ok  = !i_item.unit_code[31]
                   && (i_item.unit_code <= 32'(UNIT_MAX));
    assign batt_ok  = !i_item.batt_value[31]
                   && (i_item.batt_value <= 32'(clw_pkg::BATT_MAX));
    assign route_new = route_ok ? i_item.route_code[3:0] : 4'd0;
    assign dist_new  = i_item.dist_value[31] ? 31'd0 : i_item.dist_value[30:0];
    assign unit_new  = unit_ok ? i_item.unit_code[1:0] : 2'd0;
    assign batt_new  = batt_ok ? i_item.batt_value[7:0] : clw_pkg::BATT_UNKNOWN;

    // Advance the state by one item
    always_comb begin
        n_st  = i_state;
        dirty = 1'b0;
        unique case (i_item.opcode)
            clw_pkg::OP_TICK: begin
                // Heartbeat countdown first, then maneuver countdown
                if (i_state.beat_armed) begin
                    if (i_state.beat_left_ms <= 28'd1) begin
                        n_st.beat_armed   = 1'b0;
                        n_st.beat_left_ms = 28'd0;
                        n_st.companion_ok = 1'b0;
                        n_st.route_held   = 4'd0;
                        dirty             = 1'b1;
                    end else begin
                        n_st.beat_left_ms = i_state.beat_left_ms - 28'd1;
                    end
                end
                if (i_state.route_armed) begin
                    if (i_state.route_left_ms <= 20'd1) begin
                        n_st.route_armed   = 1'b0;
                        n_st.route_left_ms = 20'd0;
                        n_st.route_held    = 4'd0;
                        dirty              = 1'b1;
                    end else begin
                        n_st.route_left_ms = i_state.route_left_ms - 20'd1;
                    end
                end
            end
            clw_pkg::OP_MSG: begin
                if (i_item.route_present) begin
                    n_st.route_held = route_new;
                    if (i_item.dist_present) begin
                        n_st.dist_held = dist_new;
                    end
                    if (i_item.unit_present) begin
                        n_st.unit_held = unit_new;
                    end
                    n_st.route_armed   = (route_new != 4'd0);
                    n_st.route_left_ms = (route_new != 4'd0) ? i_cfg.route_life_ms : 20'd0;
                    dirty              = 1'b1;
                end
                if (i_item.batt_present && (batt_new != i_state.batt_held)) begin
                    n_st.batt_held = batt_new;
                    dirty          = 1'b1;
                end
                if (i_item.beat_present) begin
                    n_st.grace_ms = grace_new;
                end
                if (!i_state.companion_ok) begin
                    n_st.companion_ok = 1'b1;
                    dirty             = 1'b1;
                end
                // Re-arm the heartbeat only while the link is up
                n_st.beat_armed   = i_state.link_state;
                n_st.beat_left_ms = i_state.link_state ? n_st.grace_ms : 28'd0;
            end
            clw_pkg::OP_LINK: begin
                n_st.link_state = i_item.link_up;
                if (!i_item.link_up) begin
                    n_st.route_held    = 4'd0;
                    n_st.route_armed   = 1'b0;
                    n_st.route_left_ms = 20'd0;
                    n_st.companion_ok  = 1'b1;
                    n_st.grace_ms      = grace_new;
                end
                n_st.beat_armed   = i_item.link_up;
                n_st.beat_left_ms = i_item.link_up ? n_st.grace_ms : 28'd0;
                dirty             = 1'b1;
            end
            default: begin
                // Unused kind: no change
                dirty = 1'b0;
            end
        endcase
    end

    assign o_state = n_st;

    // Build the result from the updated state
    assign o_result.alive        = n_st.link_state && n_st.companion_ok;
    assign o_result.route_active = (n_st.route_held != 4'd0);
    assign o_result.route_out    = n_st.route_held;
    assign o_result.dist_out     = n_st.dist_held;
    assign o_result.unit_out     = n_st.unit_held;
    assign o_result.batt_out     = n_st.batt_held;
    assign o_result.changed      = dirty;

endmodule

/* src/companion_liveness_watchdog_top.sv */
// Path: an accepted request is held in the input register, then the state update and result register
// capture its result; while the result stream is stalled the request waits in the input register.
// Throughput: one request per cycle while the result stream is not stalled; the state update is a single pass.
// Reset: synchronous, active low; restores register defaults and the reset state
// (link up, companion alive, grace 2250000 ms, no maneuver, battery unknown) at once.
module companion_liveness_watchdog_top #(
    parameter int unsigned MANEUVER_MAX = clw_pkg::MANEUVER_MAX,
    parameter int unsigned UNIT_MAX     = clw_pkg::UNIT_MAX
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata, low bit up: link_up, beat_present, beat_period_s[32], route_present,
    // route_code[32], dist_present, dist_value[32], unit_present, unit_code[32],
    // batt_present, batt_value[32], zero pad[2]
    input  logic [clw_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // tuser: opcode[2]
    input  logic [1:0]                         i_s_tuser,
    // Result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata, low bit up: alive, route_active, route_out[4], dist_out[31],
    // unit_out[2], batt_out[8], changed
    output logic [clw_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // Configuration writes
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [19:0]                        i_cfg_data
);

    clw_pkg::t_cfg    r_cfg;
    clw_pkg::t_state  r_st;
    clw_pkg::t_state  n_st;
    clw_pkg::t_item   r_in;
    clw_pkg::t_item   n_in;
    clw_pkg::t_result r_out;
    clw_pkg::t_result n_out;
    logic             r_in_valid;
    logic             r_out_valid;
    logic             advance;
    logic             s_accept;

    // Unpack the request
    assign n_in.opcode        = i_s_tuser;
    assign n_in.link_up       = i_s_tdata[0];
    assign n_in.beat_present  = i_s_tdata[1];
    assign n_in.beat_period_s = i_s_tdata[33:2];
    assign n_in.route_present = i_s_tdata[34];
    assign n_in.route_code    = i_s_tdata[66:35];
    assign n_in.dist_present  = i_s_tdata[67];
    assign n_in.dist_value    = i_s_tdata[99:68];
    assign n_in.unit_present  = i_s_tdata[100];
    assign n_in.unit_code     = i_s_tdata[132:101];
    assign n_in.batt_present  = i_s_tdata[133];
    assign n_in.batt_value    = i_s_tdata[165:134];

    // Handshakes
    assign advance     = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready  = !r_in_valid || advance;
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.period_floor_s   <= clw_pkg::FLOOR_RST;
            r_cfg.period_ceiling_s <= clw_pkg::CEILING_RST;
            r_cfg.default_period_s <= clw_pkg::DEFAULT_RST;
            r_cfg.route_life_ms    <= clw_pkg::STALE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                clw_pkg::CFG_FLOOR:   r_cfg.period_floor_s   <= i_cfg_data[15:0];
                clw_pkg::CFG_CEILING: r_cfg.period_ceiling_s <= i_cfg_data[15:0];
                clw_pkg::CFG_DEFAULT: r_cfg.default_period_s <= i_cfg_data[15:0];
                clw_pkg::CFG_STALE:   r_cfg.route_life_ms    <= i_cfg_data;
                default:              r_cfg                  <= r_cfg;
            endcase
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in <= n_in;
        end
    end

    clw_step #(
        .MANEUVER_MAX (MANEUVER_MAX),
        .UNIT_MAX     (UNIT_MAX)
    ) u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_st),
        .i_item   (r_in),
        .o_state  (n_st),
        .o_result (n_out)
    );

    // State update and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.link_state    <= 1'b1;
            r_st.companion_ok  <= 1'b1;
            r_st.beat_armed    <= 1'b1;
            r_st.beat_left_ms  <= clw_pkg::GRACE_RST;
            r_st.grace_ms      <= clw_pkg::GRACE_RST;
            r_st.route_held    <= 4'd0;
            r_st.route_armed   <= 1'b0;
            r_st.route_left_ms <= 20'd0;
            r_st.dist_held     <= 31'd0;
            r_st.unit_held     <= 2'd0;
            r_st.batt_held     <= clw_pkg::BATT_UNKNOWN;
            r_out_valid        <= 1'b0;
        end else begin
            if (advance) begin
                r_st        <= n_st;
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // Pack the result
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out.changed, r_out.batt_out, r_out.unit_out, r_out.dist_out,
                         r_out.route_out, r_out.route_active, r_out.alive};

    // A link that is down never leaves the heartbeat countdown armed
    a_beat_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.link_state |-> !r_st.beat_armed)
        else $error("heartbeat armed while link down");

    // A disarmed countdown holds zero
    a_beat_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.beat_armed |-> (r_st.beat_left_ms == 28'd0))
        else $error("disarmed heartbeat countdown not zero");

    a_route_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_st.route_armed |-> (r_st.route_left_ms == 20'd0))
        else $error("disarmed maneuver countdown not zero");

    // A held request waits while the result is stalled, and state holds with it
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !i_m_tready) |=> (r_in_valid && $stable(r_st)))
        else $error("request or state lost during stall");

endmodule

/* bench/watchdog_checker.sv */
`timescale 1ns / 100ps

module watchdog_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    input  logic                          i_s_tready,
    input  logic [clw_pkg::S_TDATA_W-1:0] i_s_tdata,
    input  logic [1:0]                    i_s_tuser,
    input  logic                          i_m_tvalid,
    input  logic                          i_m_tready,
    input  logic [clw_pkg::M_TDATA_W-1:0] i_m_tdata,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [1:0]                    i_cfg_index,
    input  logic [19:0]                   i_cfg_data,
    output int                            o_mismatches,
    output int                            o_awaiting
);

    // Limits as last written
    logic [15:0] floor_s;
    logic [15:0] ceil_s;
    logic [15:0] dflt_s;
    logic [19:0] stale_ms;

    // Predicted watchdog state
    logic        link_q;
    logic        ok_q;
    logic        beat_armed_q;
    logic [27:0] beat_left_q;
    logic [27:0] grace_q;
    logic [3:0]  route_q;
    logic        route_armed_q;
    logic [19:0] route_left_q;
    logic [30:0] dist_q;
    logic [1:0]  unit_q;
    logic [7:0]  batt_q;

    clw_pkg::t_result expected_status_q[$];
    int               mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    // Clamp a declared period (floor first, then ceiling) and scale to ms
    function automatic logic [27:0] grace_from_period(input logic [31:0] period);
        longint p;
        p = longint'(signed'(period));
        if (p < longint'(floor_s)) p = longint'(floor_s);
        if (p > longint'(ceil_s)) p = longint'(ceil_s);
        return 28'(p * longint'(clw_pkg::GRACE_MS_PER_S));
    endfunction

    function automatic clw_pkg::t_item unpack_request(
        input logic [clw_pkg::S_TDATA_W-1:0] d, input logic [1:0] kind);
        clw_pkg::t_item it;
        it.opcode        = kind;
        it.link_up       = d[0];
        it.beat_present  = d[1];
        it.beat_period_s = d[33:2];
        it.route_present = d[34];
        it.route_code    = d[66:35];
        it.dist_present  = d[67];
        it.dist_value    = d[99:68];
        it.unit_present  = d[100];
        it.unit_code     = d[132:101];
        it.batt_present  = d[133];
        it.batt_value    = d[165:134];
        return it;
    endfunction

    function automatic clw_pkg::t_result unpack_status(
        input logic [clw_pkg::M_TDATA_W-1:0] d);
        clw_pkg::t_result r;
        r.alive        = d[0];
        r.route_active = d[1];
        r.route_out    = d[5:2];
        r.dist_out     = d[36:6];
        r.unit_out     = d[38:37];
        r.batt_out     = d[46:39];
        r.changed      = d[47];
        return r;
    endfunction

    // Advance the watchdog by one request and return the status it reports
    function automatic clw_pkg::t_result advance_watchdog(input clw_pkg::t_item it);
        clw_pkg::t_result r;
        logic             dirty;
        int               code;
        logic [7:0]       next_batt;
        dirty = 1'b0;
        case (it.opcode)
            clw_pkg::OP_TICK: begin
                // Heartbeat expiry goes first, then the maneuver countdown
                if (beat_armed_q) begin
                    if (beat_left_q <= 28'd1) begin
                        beat_armed_q = 1'b0;
                        beat_left_q  = '0;
                        ok_q         = 1'b0;
                        route_q      = '0;
                        dirty        = 1'b1;
                    end else begin
                        beat_left_q = beat_left_q - 28'd1;
                    end
                end
                if (route_armed_q) begin
                    if (route_left_q <= 20'd1) begin
                        route_armed_q = 1'b0;
                        route_left_q  = '0;
                        route_q       = '0;
                        dirty         = 1'b1;
                    end else begin
                        route_left_q = route_left_q - 20'd1;
                    end
                end
            end
            clw_pkg::OP_MSG: begin
                if (it.route_present) begin
                    code    = signed'(it.route_code);
                    route_q = (code > 0 && code <= int'(clw_pkg::MANEUVER_MAX)) ?
                              it.route_code[3:0] : 4'd0;
                    if (it.dist_present)
                        dist_q = it.dist_value[31] ? 31'd0 : it.dist_value[30:0];
                    if (it.unit_present) begin
                        code   = signed'(it.unit_code);
                        unit_q = (code >= 0 && code <= int'(clw_pkg::UNIT_MAX)) ?
                                 it.unit_code[1:0] : 2'd0;
                    end
                    route_armed_q = (route_q != 4'd0);
                    route_left_q  = route_armed_q ? stale_ms : 20'd0;
                    dirty         = 1'b1;
                end
                if (it.batt_present) begin
                    code      = signed'(it.batt_value);
                    next_batt = (code >= 0 && code <= int'(clw_pkg::BATT_MAX)) ?
                                it.batt_value[7:0] : clw_pkg::BATT_UNKNOWN;
                    if (next_batt != batt_q) begin
                        batt_q = next_batt;
                        dirty  = 1'b1;
                    end
                end
                if (it.beat_present) grace_q = grace_from_period(it.beat_period_s);
                if (!ok_q) begin
                    ok_q  = 1'b1;
                    dirty = 1'b1;
                end
                beat_armed_q = link_q;
                beat_left_q  = link_q ? grace_q : 28'd0;
            end
            clw_pkg::OP_LINK: begin
                link_q = it.link_up;
                if (!link_q) begin
                    route_q       = '0;
                    route_armed_q = 1'b0;
                    route_left_q  = '0;
                    ok_q          = 1'b1;
                    grace_q       = grace_from_period({16'd0, dflt_s});
                end
                beat_armed_q = link_q;
                beat_left_q  = link_q ? grace_q : 28'd0;
                dirty        = 1'b1;
            end
            default: ;
        endcase
        r.alive        = link_q & ok_q;
        r.route_active = (route_q != 4'd0);
        r.route_out    = route_q;
        r.dist_out     = dist_q;
        r.unit_out     = unit_q;
        r.batt_out     = batt_q;
        r.changed      = dirty;
        return r;
    endfunction

    // Track limits, compare statuses, predict new requests
    always @(posedge i_clk) begin
        clw_pkg::t_result got;
        clw_pkg::t_result want;
        if (!i_rst_n) begin
            floor_s       = clw_pkg::FLOOR_RST;
            ceil_s        = clw_pkg::CEILING_RST;
            dflt_s        = clw_pkg::DEFAULT_RST;
            stale_ms      = clw_pkg::STALE_RST;
            link_q        = 1'b1;
            ok_q          = 1'b1;
            beat_armed_q  = 1'b1;
            beat_left_q   = clw_pkg::GRACE_RST;
            grace_q       = clw_pkg::GRACE_RST;
            route_q       = '0;
            route_armed_q = 1'b0;
            route_left_q  = '0;
            dist_q        = '0;
            unit_q        = '0;
            batt_q        = clw_pkg::BATT_UNKNOWN;
            expected_status_q.delete();
            o_awaiting <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    clw_pkg::CFG_FLOOR:   floor_s  = i_cfg_data[15:0];
                    clw_pkg::CFG_CEILING: ceil_s   = i_cfg_data[15:0];
                    clw_pkg::CFG_DEFAULT: dflt_s   = i_cfg_data[15:0];
                    clw_pkg::CFG_STALE:   stale_ms = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                got = unpack_status(i_m_tdata);
                if (expected_status_q.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: status 0x%0h arrived with nothing outstanding",
                                 $time, i_m_tdata);
                    mismatch_count++;
                end else begin
                    want = expected_status_q.pop_front();
                    if (got.alive !== want.alive || got.route_active !== want.route_active ||
                        got.route_out !== want.route_out || got.dist_out !== want.dist_out ||
                        got.unit_out !== want.unit_out || got.batt_out !== want.batt_out ||
                        got.changed !== want.changed) begin
                        if (mismatch_count < 10)
                            $display({"%0t: status mismatch (expected/actual): alive %0b/%0b",
                                      " active %0b/%0b route %0d/%0d dist %0d/%0d",
                                      " unit %0d/%0d batt %0d/%0d changed %0b/%0b"},
                                     $time, want.alive, got.alive,
                                     want.route_active, got.route_active,
                                     want.route_out, got.route_out,
                                     want.dist_out, got.dist_out,
                                     want.unit_out, got.unit_out,
                                     $signed(want.batt_out), $signed(got.batt_out),
                                     want.changed, got.changed);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_status_q.push_back(
                    advance_watchdog(unpack_request(i_s_tdata, i_s_tuser)));
            o_awaiting <= expected_status_q.size();
        end
    end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         PHASE_ITEMS = 260;
    localparam int         HOLD_CYCLES = 300;
    localparam int         SETTLE      = 4;
    localparam int         TIMEOUT_NS  = 10_000_000;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_s_tvalid  = 1'b0;
    logic [clw_pkg::S_TDATA_W-1:0] i_s_tdata   = '0;
    logic [1:0]                    i_s_tuser   = clw_pkg::OP_TICK;
    logic                          i_m_tready  = 1'b0;
    logic                          i_cfg_valid = 1'b0;
    logic [1:0]                    i_cfg_index = clw_pkg::CFG_FLOOR;
    logic [19:0]                   i_cfg_data  = '0;
    logic                          o_s_tready;
    logic                          o_m_tvalid;
    logic [clw_pkg::M_TDATA_W-1:0] o_m_tdata;
    logic                          o_cfg_ready;

    int mismatches;
    int awaiting;

    // Idling controls for sender and receiver
    bit sender_idles      = 1'b1;
    bit results_stall     = 1'b1;
    bit hold_results_req  = 1'b0;
    int floor_s           = int'(clw_pkg::FLOOR_RST);
    int ceil_s            = int'(clw_pkg::CEILING_RST);

    companion_liveness_watchdog_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    watchdog_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_awaiting   (awaiting)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("Regression FAIL");
        $finish;
    end

    // Receiver: random back-pressure bursts plus one long hold on request
    initial begin
        forever begin
            if (hold_results_req) begin
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_results_req = 1'b0;
            end else if (results_stall && $urandom_range(0, 99) < 10) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic logic [clw_pkg::S_TDATA_W-1:0] pack_request(input clw_pkg::t_item it);
        return {2'b00, it.batt_value, it.batt_present, it.unit_code, it.unit_present,
                it.dist_value, it.dist_present, it.route_code, it.route_present,
                it.beat_period_s, it.beat_present, it.link_up};
    endfunction

    function automatic clw_pkg::t_item bare_item(input logic [1:0] op, input logic lk);
        clw_pkg::t_item it;
        it         = '0;
        it.opcode  = op;
        it.link_up = lk;
        return it;
    endfunction

    function automatic clw_pkg::t_item message(input int bp, input logic [31:0] bv,
                                               input int rp, input logic [31:0] rv,
                                               input int dp, input logic [31:0] dv,
                                               input int up, input logic [31:0] uv,
                                               input int ap, input logic [31:0] av);
        clw_pkg::t_item it;
        it               = bare_item(clw_pkg::OP_MSG, 1'b0);
        it.beat_present  = 1'(bp);
        it.beat_period_s = bv;
        it.route_present = 1'(rp);
        it.route_code    = rv;
        it.dist_present  = 1'(dp);
        it.dist_value    = dv;
        it.unit_present  = 1'(up);
        it.unit_code     = uv;
        it.batt_present  = 1'(ap);
        it.batt_value    = av;
        return it;
    endfunction

    // Value biased toward the edges of [lo, hi], sometimes fully random
    function automatic logic [31:0] pick_field(input int lo, input int hi);
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0:       v = $urandom;
            1:       v = lo + $urandom_range(0, 2) - 1;
            2:       v = hi + $urandom_range(0, 2) - 1;
            default: v = lo + $urandom_range(0, hi - lo);
        endcase
        return v;
    endfunction

    function automatic clw_pkg::t_item random_request();
        clw_pkg::t_item it;
        int             r;
        r = $urandom_range(0, 99);
        it.opcode        = (r < 50) ? clw_pkg::OP_TICK : (r < 82) ? clw_pkg::OP_MSG :
                           (r < 96) ? clw_pkg::OP_LINK : OP_UNUSED;
        it.link_up       = $urandom_range(0, 3) != 0;
        it.beat_present  = 1'($urandom_range(0, 1));
        it.beat_period_s = pick_field((floor_s < ceil_s) ? floor_s : ceil_s,
                                      (floor_s < ceil_s) ? ceil_s : floor_s);
        it.route_present = $urandom_range(0, 4) < 3;
        it.route_code    = pick_field(1, clw_pkg::MANEUVER_MAX);
        it.dist_present  = 1'($urandom_range(0, 1));
        it.dist_value    = pick_field(0, 32'h7FFF_FFFF);
        it.unit_present  = 1'($urandom_range(0, 1));
        it.unit_code     = pick_field(0, clw_pkg::UNIT_MAX);
        it.batt_present  = 1'($urandom_range(0, 1));
        it.batt_value    = pick_field(0, clw_pkg::BATT_MAX);
        return it;
    endfunction

    // Offer one request and hold it until accepted, then maybe go quiet
    task automatic offer(input clw_pkg::t_item it);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= pack_request(it);
        i_s_tuser  <= it.opcode;
        do @(posedge i_clk); while (!o_s_tready);
        if (sender_idles && $urandom_range(0, 99) < 10) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
    endtask

    task automatic run_ticks(input int count);
        repeat (count) offer(bare_item(clw_pkg::OP_TICK, 1'($urandom_range(0, 1))));
    endtask

    // Stop offering and wait for every outstanding status
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (awaiting != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // Write all four limit registers in one burst; only called when idle
    task automatic program_limits(input int floor_v, input int ceil_v,
                                  input int dflt_v, input int stale_v);
        logic [1:0]  idx [4];
        logic [19:0] vals [4];
        idx  = '{clw_pkg::CFG_FLOOR, clw_pkg::CFG_CEILING, clw_pkg::CFG_DEFAULT,
                 clw_pkg::CFG_STALE};
        vals = '{floor_v[19:0], ceil_v[19:0], dflt_v[19:0], stale_v[19:0]};
        i_cfg_valid <= 1'b1;
        for (int r = 0; r < 4; r++) begin
            i_cfg_index <= idx[r];
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
        floor_s = floor_v;
        ceil_s  = ceil_v;
    endtask

    initial begin
        clw_pkg::t_item it;
        int             counted;
        int             floors [6];
        int             ceils  [6];
        int             dflts  [6];
        int             stales [6];

        floors = '{15,  1,     65535, 500, 1, 1};
        ceils  = '{3600, 65535, 65535, 20,  1, 1};
        dflts  = '{900,  1,     65535, 7,   1, 300};
        stales = '{40,   1,     1048575, 3, 1, 17};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, validation corners, battery-only updates
        offer(bare_item(clw_pkg::OP_TICK, 1'b0));
        it = '1;
        it.opcode = OP_UNUSED;
        offer(it);
        offer(message(1, 15, 1, 1, 1, 32'h7FFF_FFFF, 1, 3, 1, 100));
        offer(message(1, 32'h8000_0000, 1, 15, 1, 32'h8000_0000, 1, 4, 1, 101));
        offer(message(1, 32'h7FFF_FFFF, 1, 16, 1, 5, 1, 32'hFFFF_FFFF, 1, 0));
        offer(message(1, 0, 1, 0, 0, 7, 0, 2, 1, 0));
        offer(message(0, 0, 0, 0, 0, 0, 0, 0, 1, 0));
        offer(message(0, 0, 0, 0, 0, 0, 0, 0, 1, 32'hFFFF_FFFF));
        offer(message(0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h8000_0000));
        offer(message(0, 0, 1, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 1, 50));
        offer(message(0, 0, 1, 32'hFFFF_FFFF, 0, 0, 1, 32'h8000_0000, 0, 0));
        offer(message(0, 0, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        offer(message(0, 0, 1, 5, 1, 1000, 1, 2, 0, 0));
        run_ticks(2);
        offer(message(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        run_ticks(1);
        // Link drop, a message while down, then recovery
        offer(bare_item(clw_pkg::OP_LINK, 1'b0));
        offer(message(1, 60, 1, 7, 0, 0, 0, 0, 1, 77));
        run_ticks(1);
        offer(bare_item(clw_pkg::OP_LINK, 1'b1));
        offer(bare_item(clw_pkg::OP_LINK, 1'b1));
        run_ticks(1);
        offer(message(0, '1, 0, '1, 0, '1, 0, '1, 0, '1));
        drain();

        // Heartbeat and maneuver expiring on the same tick: zero grace, one-tick lifetime
        program_limits(0, 0, 1, 1);
        offer(message(1, 1, 1, 3, 1, 42, 1, 1, 0, 0));
        run_ticks(3);
        offer(message(0, 0, 1, 9, 0, 0, 0, 0, 0, 0));
        drain();

        // Heartbeat expiry first; the maneuver countdown runs out later
        program_limits(0, 0, 1, 5);
        offer(message(1, 1, 1, 4, 0, 0, 0, 0, 0, 0));
        run_ticks(8);
        offer(bare_item(clw_pkg::OP_LINK, 1'b0));
        offer(bare_item(clw_pkg::OP_LINK, 1'b1));
        run_ticks(3);
        drain();

        // Long receiver hold while requests keep coming back to back
        sender_idles = 1'b0;
        hold_results_req = 1'b1;
        repeat (60) offer(random_request());
        drain();

        // Random phases across limit settings; the last one runs without idling
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 4) begin
                floors[ph] = $urandom_range(1, 65535);
                ceils[ph]  = $urandom_range(1, 65535);
                dflts[ph]  = $urandom_range(1, 65535);
                stales[ph] = $urandom_range(1, 64);
            end
            program_limits(floors[ph], ceils[ph], dflts[ph], stales[ph]);
            sender_idles  = (ph != 2) && (ph != 5);
            results_stall = (ph != 1) && (ph != 5);
            counted = 0;
            while (counted < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    repeat ($urandom_range(2, 50)) begin
                        offer(bare_item(clw_pkg::OP_TICK, 1'($urandom_range(0, 1))));
                        counted++;
                    end
                end else begin
                    it = random_request();
                    offer(it);
                    if (it.opcode != OP_UNUSED) counted++;
                end
            end
            drain();
        end

        if (mismatches == 0 && awaiting == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
